// ===== rtl/ready_queue_with_selectors_macros.svh =====
// Assertion macros for the ready queue RTL.
// Included by the top level, which checks its own logic; depends on nothing.
`ifndef READY_QUEUE_WITH_SELECTORS_MACROS_SVH
`define READY_QUEUE_WITH_SELECTORS_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define RQS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define RQS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rqs_pkg.sv =====
// Types and constants of the ready queue with selectors.
// Used by rqs_cell and ready_queue_with_selectors; depends on nothing.
package rqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    typedef logic [15:0] id_t;
    typedef logic [7:0]  prio_t;
    typedef logic [7:0]  burst_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        op_t    operation;
        id_t    process_id;
        prio_t  priority_req;
        burst_t burst_count;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        id_t        taken_id;
        logic [4:0] queue_length;
        logic       queue_empty;
        id_t        head_id;
        id_t        lowest_value_id;
        id_t        highest_value_id;
        id_t        fewest_bursts_id;
    } rsp_t;

    // One queue slot as it moves along the row of cells.
    typedef struct packed {
        logic   valid;
        id_t    id;
        prio_t  prio;
        burst_t bursts;
    } entry_t;

    localparam entry_t ENTRY_NONE = '0;

    // Running selector results handed from cell to cell.
    typedef struct packed {
        logic   any;
        prio_t  lo_v;
        id_t    lo_id;
        prio_t  hi_v;
        id_t    hi_id;
        burst_t few_v;
        id_t    few_id;
    } sel_t;

    localparam sel_t SEL_NONE = '0;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic load;
        logic shift_all;
        logic shift_marked;
        logic clear_mark;
    } cell_ctrl_t;

endpackage

// ===== rtl/rqs_cell.sv =====
// One slot of the ready queue: entry storage, removal mark and selector stage.
// Depends on rqs_pkg.
module rqs_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  rqs_pkg::cell_ctrl_t ctrl,
    input  logic                wr_sel,
    input  rqs_pkg::entry_t     new_entry,
    input  rqs_pkg::entry_t     right_entry,
    input  rqs_pkg::id_t        key_id,
    input  logic                left_mark,
    input  rqs_pkg::sel_t       left_sel,
    output rqs_pkg::entry_t     entry,
    output logic                mark,
    output rqs_pkg::sel_t       sel
);

    logic            valid_reg;
    logic            valid_next;
    rqs_pkg::entry_t data_reg;
    rqs_pkg::entry_t data_next;
    logic            mark_reg;
    logic            mark_next;
    rqs_pkg::sel_t   sel_reg;
    rqs_pkg::sel_t   sel_next;
    logic            match;

    assign match = valid_reg && (data_reg.id == key_id);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.load && wr_sel) begin
            valid_next = 1'b1;
            data_next  = new_entry;
        end else if (ctrl.shift_all || (ctrl.shift_marked && mark_reg)) begin
            valid_next = right_entry.valid;
            data_next  = right_entry;
        end
    end

    // The mark says that this slot or an earlier one holds the id being removed.
    assign mark_next = ctrl.clear_mark ? 1'b0 : (match || left_mark);

    // Later entries win only on a strict improvement, so ties stay with the earliest.
    always_comb begin
        sel_next = left_sel;
        if (valid_reg) begin
            if (!left_sel.any) begin
                sel_next.any    = 1'b1;
                sel_next.lo_v   = data_reg.prio;
                sel_next.lo_id  = data_reg.id;
                sel_next.hi_v   = data_reg.prio;
                sel_next.hi_id  = data_reg.id;
                sel_next.few_v  = data_reg.bursts;
                sel_next.few_id = data_reg.id;
            end else begin
                if (data_reg.prio < left_sel.lo_v) begin
                    sel_next.lo_v  = data_reg.prio;
                    sel_next.lo_id = data_reg.id;
                end
                if (data_reg.prio > left_sel.hi_v) begin
                    sel_next.hi_v  = data_reg.prio;
                    sel_next.hi_id = data_reg.id;
                end
                if (data_reg.bursts < left_sel.few_v) begin
                    sel_next.few_v  = data_reg.bursts;
                    sel_next.few_id = data_reg.id;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        sel_reg  <= sel_next;
    end

    always_comb begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

    assign mark = mark_reg;
    assign sel  = sel_reg;

endmodule

// ===== rtl/ready_queue_with_selectors.sv =====
// Top level of the ready queue with selectors: controller and row of cells.
// Depends on rqs_pkg, rqs_cell and ready_queue_with_selectors_macros.svh.
//
//  Channel | Ports                          | Carries
//  --------+--------------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_req        | one request: operation, id, priority, bursts
//  result  | m_valid, m_ready, m_rsp        | status, taken id, length, selectors
//
// m_valid rises once the request has passed through the SEARCH (removal by id only),
// SETTLE and DONE states, since the match mark and then the selector results each walk
// the row of cells one cell per cycle.
// One request is worked on at a time; the next is taken while the result still waits.
// Reset (aresetn low at a clock edge) empties the queue and drops any pending result.
// A stalled result channel holds the finished request in the DONE state.
`include "ready_queue_with_selectors_macros.svh"

module ready_queue_with_selectors #(
    parameter int QUEUE_DEPTH = rqs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rqs_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output rqs_pkg::rsp_t m_rsp
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SETTLE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [OCC_W-1:0]    occ_reg;
    rqs_pkg::id_t        pid_reg;
    logic [1:0]          status_reg;
    rqs_pkg::id_t        taken_reg;
    logic                m_valid_reg;
    rqs_pkg::rsp_t       m_rsp_reg;

    rqs_pkg::cell_ctrl_t ctrl;
    rqs_pkg::entry_t     new_entry;
    rqs_pkg::entry_t     entry_q [QUEUE_DEPTH+1];
    logic                mark_q  [QUEUE_DEPTH+1];
    rqs_pkg::sel_t       sel_q   [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] wr_sel;

    logic accept;
    logic full;
    logic empty;
    logic cnt_last;
    logic found;
    logic out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign full     = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty    = (occ_reg == '0);
    assign cnt_last = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign found    = mark_q[QUEUE_DEPTH];
    assign out_free = !m_valid_reg || m_ready;

    assign new_entry.valid  = 1'b1;
    assign new_entry.id     = s_req.process_id;
    assign new_entry.prio   = s_req.priority_req;
    assign new_entry.bursts = s_req.burst_count;

    // Commands to the cells act at the same edge as the controller's decision.
    always_comb begin
        ctrl = '0;
        if (accept) begin
            unique case (s_req.operation)
                rqs_pkg::OP_ENQUEUE: ctrl.load       = !full;
                rqs_pkg::OP_DEQUEUE: ctrl.shift_all  = !empty;
                rqs_pkg::OP_REMOVE:  ctrl.clear_mark = 1'b1;
                rqs_pkg::OP_STATUS:  ctrl            = '0;
                default:             ctrl            = '0;
            endcase
        end
        if (state_reg == S_SEARCH && cnt_last) begin
            ctrl.shift_marked = found;
        end
    end

    // The row of cells. Cell 0 is the head; data moves toward it on a dequeue or
    // removal, and marks and selector results move away from it every cycle.
    assign entry_q[QUEUE_DEPTH] = rqs_pkg::ENTRY_NONE;
    assign mark_q[0]            = 1'b0;
    assign sel_q[0]             = rqs_pkg::SEL_NONE;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        assign wr_sel[i] = (occ_reg == OCC_W'(i));

        rqs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .wr_sel      (wr_sel[i]),
            .new_entry   (new_entry),
            .right_entry (entry_q[i+1]),
            .key_id      (pid_reg),
            .left_mark   (mark_q[i]),
            .left_sel    (sel_q[i]),
            .entry       (entry_q[i]),
            .mark        (mark_q[i+1]),
            .sel         (sel_q[i+1])
        );
    end

    // Controller: state, counters, queue length and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A result taken in the same cycle as a new one is loaded stays valid.
            if (m_valid_reg && m_ready && !(state_reg == S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        pid_reg <= s_req.process_id;
                        cnt_reg <= '0;
                        unique case (s_req.operation)
                            rqs_pkg::OP_ENQUEUE: begin
                                taken_reg <= '0;
                                state_reg <= S_SETTLE;
                                if (full) begin
                                    status_reg <= rqs_pkg::ST_FULL;
                                end else begin
                                    status_reg <= rqs_pkg::ST_OK;
                                    occ_reg    <= occ_reg + 1'b1;
                                end
                            end
                            rqs_pkg::OP_DEQUEUE: begin
                                state_reg <= S_SETTLE;
                                if (empty) begin
                                    status_reg <= rqs_pkg::ST_EMPTY;
                                    taken_reg  <= '0;
                                end else begin
                                    status_reg <= rqs_pkg::ST_OK;
                                    taken_reg  <= entry_q[0].id;
                                    occ_reg    <= occ_reg - 1'b1;
                                end
                            end
                            rqs_pkg::OP_REMOVE: begin
                                status_reg <= rqs_pkg::ST_OK;
                                taken_reg  <= '0;
                                state_reg  <= S_SEARCH;
                            end
                            default: begin
                                status_reg <= rqs_pkg::ST_OK;
                                taken_reg  <= '0;
                                state_reg  <= S_SETTLE;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (cnt_last) begin
                        cnt_reg   <= '0;
                        state_reg <= S_SETTLE;
                        if (found) begin
                            // The removed entry carries exactly the id searched for.
                            taken_reg <= pid_reg;
                            occ_reg   <= occ_reg - 1'b1;
                        end else begin
                            status_reg <= rqs_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SETTLE: begin
                    if (cnt_last) begin
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_rsp_reg.status           <= status_reg;
                        m_rsp_reg.taken_id         <= taken_reg;
                        m_rsp_reg.queue_length     <= 5'(occ_reg);
                        m_rsp_reg.queue_empty      <= empty;
                        m_rsp_reg.head_id          <= entry_q[0].valid ? entry_q[0].id : '0;
                        m_rsp_reg.lowest_value_id  <=
                            sel_q[QUEUE_DEPTH].any ? sel_q[QUEUE_DEPTH].lo_id : '0;
                        m_rsp_reg.highest_value_id <=
                            sel_q[QUEUE_DEPTH].any ? sel_q[QUEUE_DEPTH].hi_id : '0;
                        m_rsp_reg.fewest_bursts_id <=
                            sel_q[QUEUE_DEPTH].any ? sel_q[QUEUE_DEPTH].few_id : '0;
                        state_reg                  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // The length never goes past the number of cells.
    `RQS_ASSERT_NOW(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= OCC_W'(QUEUE_DEPTH),
        "queue length exceeds depth")

    // The head cell holds an entry exactly when the queue is not empty.
    `RQS_ASSERT_NOW(a_head_valid, aclk, aresetn, 1'b1, entry_q[0].valid == !empty,
        "head cell validity disagrees with queue length")

    // A failed request never reports a taken id.
    `RQS_ASSERT_NOW(a_fail_no_id, aclk, aresetn,
        m_valid_reg && (m_rsp_reg.status != rqs_pkg::ST_OK), m_rsp_reg.taken_id == '0,
        "failed request reports a taken id")

    // A new result appears only when the controller leaves the DONE state.
    `RQS_ASSERT_NEXT(a_rsp_from_done, aclk, aresetn,
        !m_valid_reg && state_reg != S_DONE, !m_valid_reg,
        "result raised outside the DONE state")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for ready_queue_with_selectors: directed and random requests.
// Depends on rqs_pkg and the ready_queue_with_selectors RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
    import rqs_pkg::*;

    localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
    // The slowest request is a removal by id, which searches and then settles.
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 20;
    // About 920 requests, each with its own work plus stalls and gaps,
    // taken several times over.
    localparam int CYCLE_LIMIT = 400000;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    req_t  s_req;
    logic  m_valid;
    logic  m_ready;
    rsp_t  m_rsp;

    // Shadow copy of the queue, head first, kept in step with accepted requests.
    id_t    shadow_id[$];
    prio_t  shadow_prio[$];
    burst_t shadow_bursts[$];

    // Responses predicted for accepted requests, oldest first.
    rsp_t   pending_responses[$];

    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int responses_checked;
    int mismatch_count;
    int status_seen[4];
    int cycle_count;

    ready_queue_with_selectors #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always #5 aclk = ~aclk;

    // Hard stop in case the block hangs or loses a response.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("ready_queue_with_selectors regression: fail");
            $finish;
        end
    end

    // The result side stalls at random; the rate is set per test phase.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Applies one request to the shadow queue and returns the response the
    // block must give. Ties in every selector go to the earliest arrival, which
    // falls out of scanning from the head with strict comparisons.
    function automatic rsp_t predict_response(req_t r);
        rsp_t   rsp;
        int     hit;
        prio_t  lo_v;
        prio_t  hi_v;
        burst_t few_v;
        rsp = '0;
        rsp.status = ST_OK;
        hit = -1;
        case (r.operation)
            OP_ENQUEUE: begin
                if (shadow_id.size() >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_id.push_back(r.process_id);
                    shadow_prio.push_back(r.priority_req);
                    shadow_bursts.push_back(r.burst_count);
                end
            end
            OP_DEQUEUE: begin
                if (shadow_id.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.taken_id = shadow_id.pop_front();
                    void'(shadow_prio.pop_front());
                    void'(shadow_bursts.pop_front());
                end
            end
            OP_REMOVE: begin
                // Duplicate ids are legal; the earliest match is the one removed.
                for (int i = 0; i < shadow_id.size() && hit < 0; i++) begin
                    if (shadow_id[i] == r.process_id) hit = i;
                end
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    rsp.taken_id = shadow_id[hit];
                    shadow_id.delete(hit);
                    shadow_prio.delete(hit);
                    shadow_bursts.delete(hit);
                end
            end
            default: begin
            end
        endcase
        rsp.queue_length = 5'(shadow_id.size());
        rsp.queue_empty  = (shadow_id.size() == 0);
        // An empty queue reports zero for the head and all selectors.
        if (shadow_id.size() > 0) begin
            rsp.head_id          = shadow_id[0];
            rsp.lowest_value_id  = shadow_id[0];
            rsp.highest_value_id = shadow_id[0];
            rsp.fewest_bursts_id = shadow_id[0];
            lo_v  = shadow_prio[0];
            hi_v  = shadow_prio[0];
            few_v = shadow_bursts[0];
            for (int i = 1; i < shadow_id.size(); i++) begin
                if (shadow_prio[i] < lo_v) begin
                    lo_v = shadow_prio[i];
                    rsp.lowest_value_id = shadow_id[i];
                end
                if (shadow_prio[i] > hi_v) begin
                    hi_v = shadow_prio[i];
                    rsp.highest_value_id = shadow_id[i];
                end
                if (shadow_bursts[i] < few_v) begin
                    few_v = shadow_bursts[i];
                    rsp.fewest_bursts_id = shadow_id[i];
                end
            end
        end
        status_seen[rsp.status]++;
        return rsp;
    endfunction

    task automatic report_mismatch(string what, rsp_t want, rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
            $display("  expected st %0d taken %h len %0d empty %0d head %h lo %h hi %h few %h",
                     want.status, want.taken_id, want.queue_length, want.queue_empty,
                     want.head_id, want.lowest_value_id, want.highest_value_id,
                     want.fewest_bursts_id);
            $display("  actual   st %0d taken %h len %0d empty %0d head %h lo %h hi %h few %h",
                     got.status, got.taken_id, got.queue_length, got.queue_empty,
                     got.head_id, got.lowest_value_id, got.highest_value_id,
                     got.fewest_bursts_id);
        end
    endtask

    // Every response taken by the result channel is held against the oldest
    // prediction, one field at a time. Values are sampled at the rising edge,
    // before the block's own updates of that edge land.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no request outstanding", '0, m_rsp);
            end else begin
                want = pending_responses.pop_front();
                responses_checked++;
                if (m_rsp.status !== want.status ||
                    m_rsp.taken_id !== want.taken_id ||
                    m_rsp.queue_length !== want.queue_length ||
                    m_rsp.queue_empty !== want.queue_empty ||
                    m_rsp.head_id !== want.head_id ||
                    m_rsp.lowest_value_id !== want.lowest_value_id ||
                    m_rsp.highest_value_id !== want.highest_value_id ||
                    m_rsp.fewest_bursts_id !== want.fewest_bursts_id) begin
                    report_mismatch("response fields differ", want, m_rsp);
                end
            end
        end
    end

    // Sends one request. It is entered and left just after a falling edge.
    // Valid is lowered only for an idle gap, so back-to-back requests keep it
    // high; the prediction is made at the edge where the request is taken.
    task automatic send_request(req_t r);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req   = r;
        taken   = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            if (s_ready) begin
                taken = 1'b1;
                pending_responses.push_back(predict_response(r));
                requests_sent++;
            end
        end
        @(negedge aclk);
    endtask

    task automatic send_op(op_t op, id_t pid, prio_t pr, burst_t bc);
        req_t r;
        r.operation    = op;
        r.process_id   = pid;
        r.priority_req = pr;
        r.burst_count  = bc;
        send_request(r);
    endtask

    // Holds the sender off until every outstanding response has come back.
    task automatic wait_for_responses();
        s_valid = 1'b0;
        while (pending_responses.size() != 0) @(negedge aclk);
    endtask

    // Builds a random request. Ids come mostly from a small pool so that
    // duplicates and removals that hit are common; priorities and bursts often
    // come from a narrow range so that selector ties occur.
    function automatic req_t make_random_request(int enqueue_pct);
        req_t r;
        int   pick;
        pick = $urandom_range(0, 3);
        r.process_id = (pick == 0) ? id_t'($urandom) : id_t'($urandom_range(0, 23));
        pick = $urandom_range(0, 9);
        if (pick < 4) r.priority_req = prio_t'($urandom);
        else if (pick < 8) r.priority_req = prio_t'($urandom_range(0, 5));
        else r.priority_req = (pick == 8) ? 8'h00 : 8'hFF;
        pick = $urandom_range(0, 9);
        if (pick < 4) r.burst_count = burst_t'($urandom);
        else if (pick < 8) r.burst_count = burst_t'($urandom_range(0, 5));
        else r.burst_count = (pick == 8) ? 8'h00 : 8'hFF;
        pick = $urandom_range(0, 99);
        if (pick < enqueue_pct) begin
            r.operation = OP_ENQUEUE;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.operation = OP_DEQUEUE;
            end else if (pick < 85) begin
                r.operation = OP_REMOVE;
                // Most removals name an id that is actually queued.
                if (shadow_id.size() > 0 && $urandom_range(0, 3) != 0) begin
                    r.process_id = shadow_id[$urandom_range(0, shadow_id.size() - 1)];
                end
            end else begin
                r.operation = OP_STATUS;
            end
        end
        return r;
    endfunction

    // Every error path on an empty queue, plus a status query.
    task automatic test_empty_queue_errors();
        send_op(OP_STATUS, 16'h0000, 8'h00, 8'h00);
        send_op(OP_DEQUEUE, 16'hFFFF, 8'hFF, 8'hFF);
        send_op(OP_REMOVE, 16'h0005, 8'h00, 8'h00);
    endtask

    // Fills the queue to the brim with field extremes, duplicate ids and
    // selector ties, then overflows it and removes from it.
    task automatic test_fill_and_selectors();
        send_op(OP_ENQUEUE, 16'hFFFF, 8'h80, 8'h80);
        send_op(OP_ENQUEUE, 16'h0000, 8'h00, 8'hFF);
        send_op(OP_ENQUEUE, 16'h1234, 8'hFF, 8'h00);
        // Same id again, tying on the lowest priority and on bursts.
        send_op(OP_ENQUEUE, 16'h1234, 8'h00, 8'h00);
        // Ties with the earlier highest priority value.
        send_op(OP_ENQUEUE, 16'hAAAA, 8'hFF, 8'h00);
        for (int i = 0; i < QUEUE_DEPTH - 5; i++) begin
            send_op(OP_ENQUEUE, id_t'(16'h5555 + i), prio_t'(i * 23), burst_t'(100 + i));
        end
        // Queue is full now; this one must be refused.
        send_op(OP_ENQUEUE, 16'hBEEF, 8'h01, 8'h01);
        send_op(OP_REMOVE, 16'h1234, 8'h00, 8'h00);
        send_op(OP_REMOVE, 16'hBEEF, 8'h00, 8'h00);
        send_op(OP_DEQUEUE, 16'h0000, 8'h00, 8'h00);
        send_op(OP_STATUS, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    // Random traffic under one idle mix. The enqueue share swings every few
    // dozen requests so the queue keeps running between empty and full.
    // Halfway through, the sender waits for every response to come back.
    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        int enqueue_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        enqueue_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: enqueue_pct = 80;
                    1: enqueue_pct = 50;
                    default: enqueue_pct = 15;
                endcase
            end
            if (n == count / 2) wait_for_responses();
            send_request(make_random_request(enqueue_pct));
        end
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req         = '0;
        m_ready       = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 47;
        requests_sent     = 0;
        responses_checked = 0;
        mismatch_count    = 0;
        cycle_count       = 0;
        foreach (status_seen[i]) status_seen[i] = 0;

        // Synchronous reset, released on a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_queue_errors();
        test_fill_and_selectors();
        test_random_traffic(300, 7, 47);
        test_random_traffic(300, 47, 7);
        test_random_traffic(300, 0, 0);

        // Let the last responses drain, then give the block time to show any
        // stray output before judging the run.
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d requests and checked %0d responses under three idle mixes.",
                 requests_sent, responses_checked);
        $display("Outcomes: ok %0d, empty %0d, id not found %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL]);
        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("ready_queue_with_selectors regression: pass");
        end else begin
            $display("%0d mismatches, %0d responses missing.",
                     mismatch_count, pending_responses.size());
            $display("ready_queue_with_selectors regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rqs_pkg.sv
rtl/rqs_cell.sv
rtl/ready_queue_with_selectors.sv
verif/testbench.sv
